[hdl/mcr_pkg.sv]
`default_nettype none

package mcr_pkg;

    // field widths
    localparam int COORD_BITS = 12;
    localparam int RAD_BITS   = COORD_BITS - 1;
    localparam int PIX_BITS   = COORD_BITS + 1;
    localparam int ERR_BITS   = 14;
    localparam int CLIP_BITS  = 12;
    localparam int COLOR_BITS = 8;
    // working width of the step update, holds every intermediate without wrap
    localparam int CALC_BITS  = 18;

    // input beat layout
    localparam int IN_CX_LSB     = 0;
    localparam int IN_CY_LSB     = IN_CX_LSB + COORD_BITS;
    localparam int IN_RAD_LSB    = IN_CY_LSB + COORD_BITS;
    localparam int IN_COL_LSB    = IN_RAD_LSB + RAD_BITS;
    localparam int IN_USED_BITS  = IN_COL_LSB + COLOR_BITS;
    localparam int IN_DATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;

    // output beat layout
    localparam int OUT_PX_LSB    = 0;
    localparam int OUT_PY_LSB    = OUT_PX_LSB + PIX_BITS;
    localparam int OUT_COL_LSB   = OUT_PY_LSB + PIX_BITS;
    localparam int OUT_USED_BITS = OUT_COL_LSB + COLOR_BITS;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS = 2;
    localparam int USER_INB_BIT  = 0;
    localparam int USER_DONE_BIT = 1;

    // commands
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // register indexes
    localparam int   CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_X = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_Y = 1'b1;
    localparam logic [CLIP_BITS-1:0]    CLIP_RESET = 12'd800;

    // octant order, bit k for pixel k: swap x/y, negate dx, negate dy
    localparam int         OCT_COUNT = 8;
    localparam int         OCT_BITS  = 3;
    localparam logic [7:0] OCT_SWAP  = 8'b0110_0110;
    localparam logic [7:0] OCT_NEG_X = 8'b0011_1100;
    localparam logic [7:0] OCT_NEG_Y = 8'b1111_0000;

    // step queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    // one step handed from front to back
    typedef struct packed {
        logic                         idle;
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic signed [PIX_BITS-1:0]   step_x;
        logic [COORD_BITS-1:0]        step_y;
        logic [COLOR_BITS-1:0]        color;
        logic                         done;
    } step_t;

    // clip window
    typedef struct packed {
        logic [CLIP_BITS-1:0] x_limit;
        logic [CLIP_BITS-1:0] y_limit;
    } clip_t;

endpackage

`default_nettype wire

[hdl/mcr_front.sv]
`default_nettype none

module mcr_front (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic                                   in_cmd,
    input  wire logic signed [mcr_pkg::COORD_BITS-1:0]  in_center_x,
    input  wire logic signed [mcr_pkg::COORD_BITS-1:0]  in_center_y,
    input  wire logic [mcr_pkg::RAD_BITS-1:0]           in_radius,
    input  wire logic [mcr_pkg::COLOR_BITS-1:0]         in_color,
    input  wire logic                                   q_full,
    output logic                                        push,
    output mcr_pkg::step_t                              push_data
);

    localparam int CB = mcr_pkg::CALC_BITS;

    logic signed [mcr_pkg::COORD_BITS-1:0] cx_reg, cy_reg;
    logic signed [mcr_pkg::PIX_BITS-1:0]   sx_reg;
    logic [mcr_pkg::COORD_BITS-1:0]        sy_reg;
    logic signed [mcr_pkg::ERR_BITS-1:0]   err_reg;
    logic [mcr_pkg::COLOR_BITS-1:0]        color_reg;
    logic                                  active_reg;

    logic accept;
    logic signed [CB-1:0] e0, x0, y0, e1, y1, x1, e2;
    logic done;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (in_cmd == mcr_pkg::CMD_ADVANCE);

    // midpoint step: y move then x move, both may fire
    always_comb begin
        e0 = CB'(err_reg);
        x0 = CB'(sx_reg);
        y0 = CB'({1'b0, sy_reg});
        if (e0 <= 0) begin
            y1 = y0 + CB'(1);
            e1 = e0 + (y0 <<< 1) + CB'(3);
        end else begin
            y1 = y0;
            e1 = e0;
        end
        if (e1 > 0) begin
            x1 = x0 - CB'(1);
            e2 = e1 - (x0 <<< 1) + CB'(1);
        end else begin
            x1 = x0;
            e2 = e1;
        end
        done = (x1 < y1);
    end

    // snapshot of the step whose pixels the back end draws
    always_comb begin
        push_data.idle     = !active_reg;
        push_data.center_x = cx_reg;
        push_data.center_y = cy_reg;
        push_data.step_x   = sx_reg;
        push_data.step_y   = sy_reg;
        push_data.color    = color_reg;
        push_data.done     = done;
    end

    // circle state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            sx_reg     <= '0;
            sy_reg     <= '0;
            err_reg    <= '0;
            color_reg  <= '0;
            active_reg <= 1'b0;
        end else if (accept) begin
            if (in_cmd == mcr_pkg::CMD_START) begin
                cx_reg     <= in_center_x;
                cy_reg     <= in_center_y;
                sx_reg     <= mcr_pkg::PIX_BITS'({1'b0, in_radius});
                sy_reg     <= '0;
                err_reg    <= '0;
                color_reg  <= in_color;
                active_reg <= 1'b1;
            end else if (active_reg) begin
                sx_reg     <= x1[mcr_pkg::PIX_BITS-1:0];
                sy_reg     <= y1[mcr_pkg::COORD_BITS-1:0];
                err_reg    <= e2[mcr_pkg::ERR_BITS-1:0];
                active_reg <= !done;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/mcr_queue.sv]
`default_nettype none

module mcr_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire mcr_pkg::step_t push_data,
    input  wire logic           pop,
    output mcr_pkg::step_t      head,
    output logic                full,
    output logic                empty
);

    mcr_pkg::step_t                   slot_reg [mcr_pkg::QUEUE_DEPTH];
    logic [mcr_pkg::QPTR_BITS-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [mcr_pkg::QCNT_BITS-1:0]    count_reg;

    assign full  = (count_reg == mcr_pkg::QCNT_BITS'(mcr_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/mcr_back.sv]
`default_nettype none

module mcr_back (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire mcr_pkg::step_t                       head,
    input  wire logic                                 q_empty,
    output logic                                      pop,
    input  wire mcr_pkg::clip_t                       clip,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [mcr_pkg::PIX_BITS-1:0]       out_pixel_x,
    output logic signed [mcr_pkg::PIX_BITS-1:0]       out_pixel_y,
    output logic [mcr_pkg::COLOR_BITS-1:0]            out_color,
    output logic                                      out_in_bounds,
    output logic                                      out_last,
    output logic                                      out_done
);

    localparam int SB = mcr_pkg::PIX_BITS + 1;

    logic [mcr_pkg::OCT_BITS-1:0] oct_reg;
    logic                         valid_reg;
    logic signed [mcr_pkg::PIX_BITS-1:0] px_reg, py_reg;
    logic [mcr_pkg::COLOR_BITS-1:0]      color_reg;
    logic inb_reg, last_reg, done_reg;

    logic load, take, oct_last;
    logic signed [SB-1:0] ext_x, ext_y, mag_a, mag_b, dx, dy, sum_x, sum_y;
    logic signed [mcr_pkg::PIX_BITS-1:0] px, py;
    logic inb;

    assign load     = !valid_reg || out_ready;
    assign take     = load && !q_empty;
    assign oct_last = (oct_reg == mcr_pkg::OCT_BITS'(mcr_pkg::OCT_COUNT - 1));
    assign pop      = take && (head.idle || oct_last);

    // octant offset and pixel position
    always_comb begin
        ext_x = SB'(head.step_x);
        ext_y = SB'({1'b0, head.step_y});
        mag_a = mcr_pkg::OCT_SWAP[oct_reg] ? ext_y : ext_x;
        mag_b = mcr_pkg::OCT_SWAP[oct_reg] ? ext_x : ext_y;
        dx    = mcr_pkg::OCT_NEG_X[oct_reg] ? -mag_a : mag_a;
        dy    = mcr_pkg::OCT_NEG_Y[oct_reg] ? -mag_b : mag_b;
        sum_x = SB'(head.center_x) + dx;
        sum_y = SB'(head.center_y) + dy;
        px    = sum_x[mcr_pkg::PIX_BITS-1:0];
        py    = sum_y[mcr_pkg::PIX_BITS-1:0];
        inb   = !px[mcr_pkg::PIX_BITS-1]
             && (px[mcr_pkg::CLIP_BITS-1:0] < clip.x_limit)
             && !py[mcr_pkg::PIX_BITS-1]
             && (py[mcr_pkg::CLIP_BITS-1:0] < clip.y_limit);
    end

    // octant counter and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oct_reg   <= '0;
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= !q_empty;
            if (take && !head.idle) begin
                oct_reg <= oct_reg + 1'b1;
            end
        end
    end

    // beat payload
    always_ff @(posedge aclk) begin
        if (take) begin
            if (head.idle) begin
                px_reg    <= '0;
                py_reg    <= '0;
                color_reg <= '0;
                inb_reg   <= 1'b0;
                last_reg  <= 1'b1;
                done_reg  <= 1'b1;
            end else begin
                px_reg    <= px;
                py_reg    <= py;
                color_reg <= head.color;
                inb_reg   <= inb;
                last_reg  <= oct_last;
                done_reg  <= oct_last && head.done;
            end
        end
    end

    assign out_valid     = valid_reg;
    assign out_pixel_x   = px_reg;
    assign out_pixel_y   = py_reg;
    assign out_color     = color_reg;
    assign out_in_bounds = inb_reg;
    assign out_last      = last_reg;
    assign out_done      = done_reg;

endmodule

`default_nettype wire

[hdl/midpoint_circle_raster.sv]
// channel   | dir | beat
// ----------+-----+-----------------------------------------------------------
// s_axis    | in  | one command: start (load circle) or advance (one step)
// m_axis    | out | one pixel: position, color, clip flag, done on last
// cfg       | in  | one register write, clip_x_limit or clip_y_limit
//
// a start gives no beat; an advance gives eight beats, one per cycle from the
// back end's octant counter unless the output stalls; an advance while idle
// gives a single beat. a two-entry step queue lets commands be taken while
// earlier steps drain. reset is synchronous on aresetn low, clip limits
// return to 800. output stalls hold the beat in the output register.
`default_nettype none

module midpoint_circle_raster (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      s_axis_tvalid,
    output logic                                           s_axis_tready,
    // center_x[11:0], center_y[23:12], radius[34:24], color[42:35], zero pad
    input  wire logic [mcr_pkg::IN_DATA_BITS-1:0]          s_axis_tdata,
    // cmd
    input  wire logic                                      s_axis_tuser,
    output logic                                           m_axis_tvalid,
    input  wire logic                                      m_axis_tready,
    // pixel_x[12:0], pixel_y[25:13], pixel_color[33:26], zero pad
    output logic [mcr_pkg::OUT_DATA_BITS-1:0]              m_axis_tdata,
    // in_bounds[0], done_res[1]
    output logic [mcr_pkg::OUT_USER_BITS-1:0]              m_axis_tuser,
    output logic                                           m_axis_tlast,
    input  wire logic                                      cfg_wr_en,
    input  wire logic [mcr_pkg::CFG_IDX_BITS-1:0]          cfg_index,
    input  wire logic [mcr_pkg::CLIP_BITS-1:0]             cfg_wdata
);

    mcr_pkg::clip_t clip_reg;
    mcr_pkg::step_t push_data, head;
    logic push, pop, q_full, q_empty;

    logic signed [mcr_pkg::PIX_BITS-1:0] pix_x, pix_y;
    logic [mcr_pkg::COLOR_BITS-1:0]      pix_color;
    logic pix_inb, pix_done;

    // clip registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_reg.x_limit <= mcr_pkg::CLIP_RESET;
            clip_reg.y_limit <= mcr_pkg::CLIP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mcr_pkg::REG_CLIP_X: clip_reg.x_limit <= cfg_wdata;
                mcr_pkg::REG_CLIP_Y: clip_reg.y_limit <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // command decode and circle state
    mcr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_cmd      (s_axis_tuser),
        .in_center_x (s_axis_tdata[mcr_pkg::IN_CX_LSB +: mcr_pkg::COORD_BITS]),
        .in_center_y (s_axis_tdata[mcr_pkg::IN_CY_LSB +: mcr_pkg::COORD_BITS]),
        .in_radius   (s_axis_tdata[mcr_pkg::IN_RAD_LSB +: mcr_pkg::RAD_BITS]),
        .in_color    (s_axis_tdata[mcr_pkg::IN_COL_LSB +: mcr_pkg::COLOR_BITS]),
        .q_full      (q_full),
        .push        (push),
        .push_data   (push_data)
    );

    // steps waiting for the pixel stage
    mcr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // eight pixels per step
    mcr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .q_empty       (q_empty),
        .pop           (pop),
        .clip          (clip_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_pixel_x   (pix_x),
        .out_pixel_y   (pix_y),
        .out_color     (pix_color),
        .out_in_bounds (pix_inb),
        .out_last      (m_axis_tlast),
        .out_done      (pix_done)
    );

    // output beat packing
    assign m_axis_tdata = mcr_pkg::OUT_DATA_BITS'({pix_color, pix_y, pix_x});
    assign m_axis_tuser = {pix_done, pix_inb};

endmodule

`default_nettype wire

[hdl/mcr_checker.sv]
`default_nettype none

module mcr_checker (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    input  wire logic [mcr_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,
    input  wire logic [mcr_pkg::OUT_USER_BITS-1:0]     m_axis_tuser,
    input  wire logic                                  m_axis_tlast
);

    // no beat offered right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output beat offered after reset");

    // a stalled beat stays put
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

    // done only rides on the closing beat of a command
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[mcr_pkg::USER_DONE_BIT] |-> m_axis_tlast)
        else $error("done flagged on a beat that is not last");

    // negative coordinates are never inside the clip window
    a_neg_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid
        && (m_axis_tdata[mcr_pkg::OUT_PX_LSB + mcr_pkg::PIX_BITS - 1]
            || m_axis_tdata[mcr_pkg::OUT_PY_LSB + mcr_pkg::PIX_BITS - 1])
        |-> !m_axis_tuser[mcr_pkg::USER_INB_BIT])
        else $error("negative pixel flagged in bounds");

endmodule

bind midpoint_circle_raster mcr_checker u_mcr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[tb/sv/midpoint_circle_raster_tb.sv]
`timescale 1ns / 1ps

module midpoint_circle_raster_tb;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int REPORT_MAX    = 40;

    // receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_MOSTLY = 3;

    typedef struct packed {
        logic signed [mcr_pkg::PIX_BITS-1:0] x;
        logic signed [mcr_pkg::PIX_BITS-1:0] y;
        logic [mcr_pkg::COLOR_BITS-1:0]      color;
        logic                                inb;
        logic                                last;
        logic                                done;
    } pixel_t;

    logic                                aclk          = 1'b0;
    logic                                aresetn       = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    wire                                 s_axis_tready;
    logic [mcr_pkg::IN_DATA_BITS-1:0]    s_axis_tdata  = '0;
    logic                                s_axis_tuser  = mcr_pkg::CMD_START;
    wire                                 m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    wire  [mcr_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata;
    wire  [mcr_pkg::OUT_USER_BITS-1:0]   m_axis_tuser;
    wire                                 m_axis_tlast;
    logic                                cfg_wr_en     = 1'b0;
    logic [mcr_pkg::CFG_IDX_BITS-1:0]    cfg_index     = mcr_pkg::REG_CLIP_X;
    logic [mcr_pkg::CLIP_BITS-1:0]       cfg_wdata     = '0;

    // circle walker state as the block should hold it
    logic signed [mcr_pkg::COORD_BITS-1:0] ctr_x     = '0;
    logic signed [mcr_pkg::COORD_BITS-1:0] ctr_y     = '0;
    logic signed [mcr_pkg::PIX_BITS-1:0]   walk_x    = '0;
    logic [mcr_pkg::COORD_BITS-1:0]        walk_y    = '0;
    logic signed [mcr_pkg::ERR_BITS-1:0]   walk_err  = '0;
    logic [mcr_pkg::COLOR_BITS-1:0]        pen_color = '0;
    logic                                  drawing   = 1'b0;
    logic [mcr_pkg::CLIP_BITS-1:0]         clip_x    = mcr_pkg::CLIP_RESET;
    logic [mcr_pkg::CLIP_BITS-1:0]         clip_y    = mcr_pkg::CLIP_RESET;

    pixel_t pixel_queue[$];

    int mismatches      = 0;
    int commands_sent   = 0;
    int circles_started = 0;
    int pixels_checked  = 0;
    int clip_writes     = 0;
    int burst_left      = 0;
    int rx_left         = 0;
    int rx_mode         = RX_OPEN;

    midpoint_circle_raster u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #HALF_PERIOD;
        aclk = 1'b1;
        #HALF_PERIOD;
    end

    // append one expected pixel at the tail
    task automatic expect_pixel(input pixel_t pix);
        pixel_queue.insert(pixel_queue.size(), pix);
    endtask

    // expected pixels for one accepted command, walker advanced afterwards
    task automatic plot_command(input logic cmd,
                                input logic [mcr_pkg::IN_DATA_BITS-1:0] beat);
        int     k;
        int     x0, y0, nx, ny, ne, dx, dy, px, py, lim_x, lim_y;
        logic   fin;
        pixel_t pix;
        if (cmd == mcr_pkg::CMD_START) begin
            ctr_x     = beat[mcr_pkg::IN_CX_LSB +: mcr_pkg::COORD_BITS];
            ctr_y     = beat[mcr_pkg::IN_CY_LSB +: mcr_pkg::COORD_BITS];
            walk_x    = {2'b00, beat[mcr_pkg::IN_RAD_LSB +: mcr_pkg::RAD_BITS]};
            walk_y    = '0;
            walk_err  = '0;
            pen_color = beat[mcr_pkg::IN_COL_LSB +: mcr_pkg::COLOR_BITS];
            drawing   = 1'b1;
            circles_started++;
        end else if (!drawing) begin
            // advance with no circle: one empty pixel marked done
            pix      = '0;
            pix.last = 1'b1;
            pix.done = 1'b1;
            expect_pixel(pix);
        end else begin
            x0    = walk_x;
            y0    = walk_y;
            nx    = x0;
            ny    = y0;
            ne    = walk_err;
            lim_x = clip_x;
            lim_y = clip_y;
            // midpoint rule, both moves allowed in one step
            if (ne <= 0) begin
                ny = ny + 1;
                ne = ne + 2 * ny + 1;
            end
            if (ne > 0) begin
                nx = nx - 1;
                ne = ne - (2 * nx + 1);
            end
            fin = (nx < ny);
            for (k = 0; k < mcr_pkg::OCT_COUNT; k++) begin
                case (k)
                    0: begin dx =  x0; dy =  y0; end
                    1: begin dx =  y0; dy =  x0; end
                    2: begin dx = -y0; dy =  x0; end
                    3: begin dx = -x0; dy =  y0; end
                    4: begin dx = -x0; dy = -y0; end
                    5: begin dx = -y0; dy = -x0; end
                    6: begin dx =  y0; dy = -x0; end
                    default: begin dx = x0; dy = -y0; end
                endcase
                px        = ctr_x + dx;
                py        = ctr_y + dy;
                pix.x     = px[mcr_pkg::PIX_BITS-1:0];
                pix.y     = py[mcr_pkg::PIX_BITS-1:0];
                px        = pix.x;
                py        = pix.y;
                pix.color = pen_color;
                pix.inb   = (px >= 0) && (px < lim_x) && (py >= 0) && (py < lim_y);
                pix.last  = (k == mcr_pkg::OCT_COUNT - 1);
                pix.done  = (k == mcr_pkg::OCT_COUNT - 1) && fin;
                expect_pixel(pix);
            end
            walk_x   = nx[mcr_pkg::PIX_BITS-1:0];
            walk_y   = ny[mcr_pkg::COORD_BITS-1:0];
            walk_err = ne[mcr_pkg::ERR_BITS-1:0];
            if (fin)
                drawing = 1'b0;
        end
    endtask

    // one command beat, sender runs in bursts with gaps between
    task automatic send_command(input logic cmd, input int cx, input int cy,
                                input int rad, input int col);
        logic [mcr_pkg::IN_DATA_BITS-1:0] beat;
        beat = '0;
        beat[mcr_pkg::IN_CX_LSB +: mcr_pkg::COORD_BITS]  = cx[mcr_pkg::COORD_BITS-1:0];
        beat[mcr_pkg::IN_CY_LSB +: mcr_pkg::COORD_BITS]  = cy[mcr_pkg::COORD_BITS-1:0];
        beat[mcr_pkg::IN_RAD_LSB +: mcr_pkg::RAD_BITS]   = rad[mcr_pkg::RAD_BITS-1:0];
        beat[mcr_pkg::IN_COL_LSB +: mcr_pkg::COLOR_BITS] = col[mcr_pkg::COLOR_BITS-1:0];
        @(negedge aclk);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 8);
        end
        burst_left    = burst_left - 1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        s_axis_tuser  <= cmd;
        do @(posedge aclk); while (s_axis_tready !== 1'b1);
        commands_sent++;
        plot_command(cmd, beat);
    endtask

    task automatic send_advance();
        send_command(mcr_pkg::CMD_ADVANCE, $urandom, $urandom, $urandom, $urandom);
    endtask

    // stop sending and wait for every expected pixel, then let the block settle
    task automatic flush_pixels();
        int guard;
        guard = 0;
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pixel_queue.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        if (pixel_queue.size() != 0) begin
            $display("%0t ns: %0d expected pixels never arrived", $time, pixel_queue.size());
            mismatches += pixel_queue.size();
            pixel_queue.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // clip register write, only with the block idle
    task automatic write_clip(input logic [mcr_pkg::CFG_IDX_BITS-1:0] idx, input int value);
        flush_pixels();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[mcr_pkg::CLIP_BITS-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == mcr_pkg::REG_CLIP_X)
            clip_x = value[mcr_pkg::CLIP_BITS-1:0];
        else
            clip_y = value[mcr_pkg::CLIP_BITS-1:0];
        clip_writes++;
    endtask

    // receiver stalls, a new random pattern is picked whenever the current run ends
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(RX_OPEN, RX_MOSTLY);
            rx_left = $urandom_range(20, 120);
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= $urandom_range(0, 1);
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    function automatic void compare_field(input string what, input int want, input int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t ns: %s expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    // pixel beat checker
    always @(posedge aclk) begin : check_pixels
        pixel_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pixel_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"%0t ns: pixel beat with nothing expected, expected none, ",
                              "actual x %0d y %0d"}, $time,
                             $signed(m_axis_tdata[mcr_pkg::OUT_PX_LSB +: mcr_pkg::PIX_BITS]),
                             $signed(m_axis_tdata[mcr_pkg::OUT_PY_LSB +: mcr_pkg::PIX_BITS]));
            end else begin
                want = pixel_queue.pop_front();
                pixels_checked++;
                compare_field("pixel_x", want.x,
                    $signed(m_axis_tdata[mcr_pkg::OUT_PX_LSB +: mcr_pkg::PIX_BITS]));
                compare_field("pixel_y", want.y,
                    $signed(m_axis_tdata[mcr_pkg::OUT_PY_LSB +: mcr_pkg::PIX_BITS]));
                compare_field("pixel_color", want.color,
                    m_axis_tdata[mcr_pkg::OUT_COL_LSB +: mcr_pkg::COLOR_BITS]);
                compare_field("in_bounds", want.inb, m_axis_tuser[mcr_pkg::USER_INB_BIT]);
                compare_field("last", want.last, m_axis_tlast);
                compare_field("done", want.done, m_axis_tuser[mcr_pkg::USER_DONE_BIT]);
            end
        end
    end

    // advance with no circle loaded, data bits ignored
    task automatic test_advance_while_idle();
        send_command(mcr_pkg::CMD_ADVANCE, 0, 0, 0, 0);
        send_command(mcr_pkg::CMD_ADVANCE, -1, -1, 2047, 255);
    endtask

    // zero radius: center pixel eight times, then idle again
    task automatic test_radius_zero();
        send_command(mcr_pkg::CMD_START, 5, 9, 0, 8'h5A);
        send_advance();
        send_advance();
    endtask

    task automatic test_small_circle();
        send_command(mcr_pkg::CMD_START, 100, 100, 3, 8'hA5);
        while (drawing)
            send_advance();
    endtask

    // tightest window, then a 2048 by 2048 window
    task automatic test_clip_corners();
        write_clip(mcr_pkg::REG_CLIP_X, 1);
        write_clip(mcr_pkg::REG_CLIP_Y, 1);
        send_command(mcr_pkg::CMD_START, 0, 0, 1, 8'h01);
        send_advance();
        write_clip(mcr_pkg::REG_CLIP_X, 2048);
        write_clip(mcr_pkg::REG_CLIP_Y, 2048);
        send_command(mcr_pkg::CMD_START, 1, 1, 1, 8'h02);
        send_advance();
    endtask

    // widest radius at opposite corners, each later start drops the circle before it
    task automatic test_abandoned_circles();
        write_clip(mcr_pkg::REG_CLIP_X, 4095);
        write_clip(mcr_pkg::REG_CLIP_Y, 4095);
        send_command(mcr_pkg::CMD_START, -2048, 2047, 2047, 255);
        repeat (3) send_advance();
        send_command(mcr_pkg::CMD_START, 2047, -2048, 2047, 0);
        repeat (2) send_advance();
        send_command(mcr_pkg::CMD_START, 0, 0, 2, 8'h0F);
        while (drawing)
            send_advance();
    endtask

    // mostly whole circles, centered near the window or anywhere, plus stray advances and cut-off starts
    task automatic test_random_circles(input int n_cmds, input int lim_x, input int lim_y);
        int target, pick, cx, cy, rad, cut, steps;
        write_clip(mcr_pkg::REG_CLIP_X, lim_x);
        write_clip(mcr_pkg::REG_CLIP_Y, lim_y);
        target = commands_sent + n_cmds;
        while (commands_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                if ($urandom_range(0, 1)) begin
                    cx = $urandom_range(0, clip_x + 40);
                    cy = $urandom_range(0, clip_y + 40);
                    cx = cx - 20;
                    cy = cy - 20;
                end else begin
                    cx = $urandom;
                    cy = $urandom;
                end
                pick = $urandom_range(0, 19);
                rad  = (pick < 16) ? $urandom_range(0, 16) :
                       (pick < 19) ? $urandom_range(17, 90) : $urandom_range(91, 160);
                send_command(mcr_pkg::CMD_START, cx, cy, rad, $urandom);
                cut   = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 4) : -1;
                steps = 0;
                while (drawing && steps != cut) begin
                    send_advance();
                    steps++;
                end
                if ($urandom_range(0, 3) == 0)
                    send_advance();
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 3)) send_advance();
            end else begin
                send_command(mcr_pkg::CMD_START, $urandom, $urandom, $urandom, $urandom);
                repeat ($urandom_range(0, 3)) send_advance();
            end
        end
    endtask

    initial begin
        #(10_000_000);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_advance_while_idle();
        test_radius_zero();
        test_small_circle();
        test_clip_corners();
        test_abandoned_circles();
        test_random_circles(60, $urandom_range(1, 2048), $urandom_range(1, 2048));
        test_random_circles(60, 4095, 4095);
        test_random_circles(60, mcr_pkg::CLIP_RESET, mcr_pkg::CLIP_RESET);
        flush_pixels();

        $display("run covered %0d commands, %0d circles started, %0d clip writes",
                 commands_sent, circles_started, clip_writes);
        $display("%0d pixel beats compared under random sender gaps and receiver stalls",
                 pixels_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
hdl/mcr_pkg.sv
hdl/mcr_front.sv
hdl/mcr_queue.sv
hdl/mcr_back.sv
hdl/midpoint_circle_raster.sv
hdl/mcr_checker.sv
tb/sv/midpoint_circle_raster_tb.sv
